FILE: design/hss_pkg.sv
// hss_pkg: shared types, codes and constants of the harmonic sum synthesizer.
// Holds the transaction structs, controller/datapath command and status groups
// and the integer quarter-wave sine evaluation used to build the sine ROM.
`timescale 1ns / 1ps

package hss_pkg;

  localparam int MAX_HARMONICS_DEF   = 16;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int PHASE_W  = 32;
  localparam int AMP_W    = 16;
  localparam int SINE_W   = 16;
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 5;
  localparam int CFG_W    = 32;

  // input command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GEN  = 1'b1;

  typedef enum logic [0:0] {
    CFG_STEP  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                    command;
    logic [3:0]              harmonic_index;
    logic signed [AMP_W-1:0] amplitude;
    logic [PHASE_W-1:0]      phase_offset;
    logic                    restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       saturated;
  } out_item_t;

  typedef struct packed {
    logic start;     // generate transaction accepted
    logic load;      // load transaction accepted
    logic issue;     // read the next harmonic into the pipeline
    logic out_load;  // saturate the sum into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_done;  // every requested harmonic has been issued
    logic pipe_busy;   // a harmonic is still in flight
    logic out_full;    // output register holds an untaken result
  } dp_status_t;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // sin(2*pi*m/N) * 32767 for 0 <= m <= N/4, Q30 Horner evaluation
  function automatic logic signed [SINE_W-1:0] quarter_sine(input logic [63:0] m,
                                                            input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (TWO_PI_Q30 * m) >> bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
    t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
    s  = (x * t) >> 30;
    r  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return SINE_W'(r);
  endfunction

endpackage

FILE: design/hss_ctrl.sv
// hss_ctrl: sequencing state machine of the harmonic sum synthesizer.
// Depends on hss_pkg for the command and status groups and command codes.
`timescale 1ns / 1ps

module hss_ctrl import hss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_command_i,
  output logic       in_stall_o,
  input  logic       out_stall_i,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  // output register empties this cycle or is already empty
  assign out_free   = !sts_i.out_full || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.start    = accept && (in_command_i == CMD_GEN);
    cmd_o.load     = accept && (in_command_i == CMD_LOAD);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.start) state_d = S_RUN;
      end
      S_RUN: begin
        if (sts_i.issue_done) begin
          state_d = S_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.pipe_busy) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == S_RUN)
    else $error("generate transaction did not start the harmonic sweep");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!sts_i.out_full || !out_stall_i))
    else $error("result overwrote an untaken output");
  a_finish_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |-> !sts_i.pipe_busy)
    else $error("sum taken while harmonics still in flight");
`endif

endmodule

FILE: design/hss_datapath.sv
// hss_datapath: harmonic tables, phase accumulators, sine ROM, shared multiplier,
// accumulator and output register. Depends on hss_pkg; driven by hss_ctrl.
`timescale 1ns / 1ps

module hss_datapath import hss_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  in_item_t         in_data_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int IDX_W   = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int CNT_W   = $clog2(MAX_HARMONICS + 1);
  localparam int SINE_N  = 1 << SINE_TABLE_BITS;
  localparam int HALF_N  = SINE_N / 2;
  localparam int QUART_N = SINE_N / 4;
  localparam int TERM_W  = 2 * AMP_W - 15;
  localparam int ACC_W   = $clog2(MAX_HARMONICS) + TERM_W;
  localparam int CMP_W   = ((ACC_W > SAMPLE_W) ? ACC_W : SAMPLE_W) + 1;

  localparam logic signed [CMP_W-1:0]    SatHi     = CMP_W'(8388607);
  localparam logic signed [CMP_W-1:0]    SatLo     = CMP_W'(-8388608);
  localparam logic signed [SAMPLE_W-1:0] SampleMax = SAMPLE_W'(8388607);
  localparam logic signed [SAMPLE_W-1:0] SampleMin = SAMPLE_W'(-8388608);

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_N];

  function automatic sine_rom_t build_sine();
    sine_rom_t             rom;
    logic [63:0]           m;
    logic signed [SINE_W-1:0] v;
    for (int k = 0; k < SINE_N; k++) begin
      m = 64'(k) & 64'(HALF_N - 1);
      if (m > 64'(QUART_N)) m = 64'(HALF_N) - m;
      v = quarter_sine(m, SINE_TABLE_BITS);
      rom[k] = (k >= HALF_N) ? -v : v;
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine();

  // configuration registers
  logic [PHASE_W-1:0] step_q;
  logic [COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_STEP:  step_q  <= cfg_data_i[PHASE_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // harmonic tables: memories with per-entry valid bits, invalid reads as zero
  logic signed [AMP_W-1:0] amp_mem [MAX_HARMONICS];
  logic [PHASE_W-1:0]      ph_mem  [MAX_HARMONICS];
  logic [MAX_HARMONICS-1:0] ent_vld_q;
  logic [31:0]             wr_idx_wide;
  logic                    wr_ok;
  logic [IDX_W-1:0]        wr_idx;
  logic [CNT_W-1:0]        rd_ptr_q;
  logic [IDX_W-1:0]        rd_idx;

  assign wr_idx_wide = 32'(in_data_i.harmonic_index);
  assign wr_ok       = wr_idx_wide < 32'(MAX_HARMONICS);
  assign wr_idx      = wr_idx_wide[IDX_W-1:0];
  assign rd_idx      = rd_ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (cmd_i.load && wr_ok) begin
      ent_vld_q[wr_idx] <= 1'b1;
    end
  end

  // stage 1: table read
  logic signed [AMP_W-1:0] amp_rd_q;
  logic [PHASE_W-1:0]      ph_rd_q;
  logic                    rd_vld_q;
  logic [PHASE_W-1:0]      s1_hp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      amp_mem[wr_idx] <= in_data_i.amplitude;
      ph_mem[wr_idx]  <= in_data_i.phase_offset;
    end
    if (cmd_i.issue) begin
      amp_rd_q <= amp_mem[rd_idx];
      ph_rd_q  <= ph_mem[rd_idx];
      rd_vld_q <= ent_vld_q[rd_idx];
    end
  end

  // sweep control and harmonic phase p * fundamental, built by repeated add
  logic [CNT_W-1:0]   n_q;
  logic [CNT_W-1:0]   n_clamped;
  logic [PHASE_W-1:0] fund_q;
  logic [PHASE_W-1:0] base_q;
  logic [PHASE_W-1:0] hp_q;
  logic [PHASE_W-1:0] base_d;

  assign n_clamped = (32'(count_q) > 32'(MAX_HARMONICS)) ? CNT_W'(MAX_HARMONICS)
                                                         : CNT_W'(count_q);
  assign base_d    = in_data_i.restart ? '0 : fund_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fund_q   <= '0;
      n_q      <= '0;
      rd_ptr_q <= '0;
    end else if (cmd_i.start) begin
      fund_q   <= base_d + step_q;
      n_q      <= n_clamped;
      rd_ptr_q <= '0;
    end else if (cmd_i.issue) begin
      rd_ptr_q <= rd_ptr_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      base_q <= base_d;
      hp_q   <= '0;
    end else if (cmd_i.issue) begin
      s1_hp_q <= hp_q;
      hp_q    <= hp_q + base_q;
    end
  end

  // pipeline valids
  logic s1_v_q, s2_v_q, s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // stage 2: sine ROM lookup on the top phase bits
  logic [PHASE_W-1:0]          ph_sum;
  logic [SINE_TABLE_BITS-1:0]  rom_addr;
  logic signed [SINE_W-1:0]    sine_q;
  logic signed [AMP_W-1:0]     amp2_q;

  assign ph_sum   = s1_hp_q + (rd_vld_q ? ph_rd_q : '0);
  assign rom_addr = ph_sum[PHASE_W-1 -: SINE_TABLE_BITS];

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      sine_q <= SineRom[rom_addr];
      amp2_q <= rd_vld_q ? amp_rd_q : '0;
    end
  end

  // stage 3: shared multiplier
  logic signed [2*AMP_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (s2_v_q) prod_q <= amp2_q * sine_q;
  end

  // stage 4: floor shift by 15 and accumulate
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc_q;

  assign term = prod_q[2*AMP_W-1:15];

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (s3_v_q) begin
      acc_q <= acc_q + ACC_W'(term);
    end
  end

  // saturation and output register
  logic signed [CMP_W-1:0] acc_ext;
  out_item_t               res;
  out_item_t               out_data_q;
  logic                    out_valid_q;

  assign acc_ext = CMP_W'(acc_q);

  always_comb begin
    if (acc_ext > SatHi) begin
      res.sample    = SampleMax;
      res.saturated = 1'b1;
    end else if (acc_ext < SatLo) begin
      res.sample    = SampleMin;
      res.saturated = 1'b1;
    end else begin
      res.sample    = SAMPLE_W'(acc_ext);
      res.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_data_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;
  assign sts_o.issue_done = (rd_ptr_q == n_q);
  assign sts_o.pipe_busy  = s1_v_q || s2_v_q || s3_v_q;
  assign sts_o.out_full   = out_valid_q;

`ifndef ASSERT_OFF
  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.saturated) |->
      (out_data_q.sample == SampleMax || out_data_q.sample == SampleMin))
    else $error("saturation flag set on an in-range sample");
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> rd_ptr_q < n_q)
    else $error("harmonic issued beyond the requested count");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled output transaction changed");
`endif

endmodule

FILE: design/harmonic_sum_synthesizer.sv
// Harmonic sum synthesizer: a load transaction (command 0) writes one amplitude /
// phase-offset entry when accepted and gives no result; a generate transaction
// (command 1) gives one saturated 24-bit sample summed over n harmonics, where n is
// harmonic_count clamped to MAX_HARMONICS; the next transaction is taken once the
// sample is loaded into the output register. The single shared 16x16 multiplier
// takes one harmonic per cycle behind a four-stage table/ROM/multiply/accumulate
// pipeline, with the sweep followed by pipeline drain and output hand-off.
// One transaction is worked on at a time; a finished sample waits in the output
// register while the next transaction is accepted. Tables read as zero after
// reset without any clearing pass. Write configuration only while idle.
`timescale 1ns / 1ps

module harmonic_sum_synthesizer import hss_pkg::*; #(
  parameter int MAX_HARMONICS   = MAX_HARMONICS_DEF,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  hss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_stall_o   (in_stall_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  hss_datapath #(
    .MAX_HARMONICS   (MAX_HARMONICS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
